/* rtl/core/xad_pkg.sv */
// ----------------------------------------------------------------------------
// XA ADPCM sample decoder package
// Shared types, widths and filter coefficient tables.
// ----------------------------------------------------------------------------
package xad_pkg;

    localparam int NUM_CHANNELS_DEFAULT = 2;
    localparam int CODE_W   = 4;
    localparam int HEADER_W = 8;
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 10;

    localparam logic [3:0] MAX_RANGE = 4'd12;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;

    typedef struct packed {
        sample_t newest;
        sample_t older;
    } hist_pair_t;

    typedef struct packed {
        logic    en;
        sample_t data;
    } hist_wr_t;

    function automatic coef_t coef_a(input logic [1:0] filt);
        coef_t k;
        case (filt)
            2'd0:    k = 10'sd0;
            2'd1:    k = 10'sd240;
            2'd2:    k = 10'sd460;
            2'd3:    k = 10'sd392;
            default: k = 10'sd0;
        endcase
        return k;
    endfunction

    function automatic coef_t coef_b(input logic [1:0] filt);
        coef_t k;
        case (filt)
            2'd0:    k = 10'sd0;
            2'd1:    k = 10'sd0;
            2'd2:    k = -10'sd208;
            2'd3:    k = -10'sd220;
            default: k = 10'sd0;
        endcase
        return k;
    endfunction

endpackage

/* rtl/core/xad_history.sv */
// ----------------------------------------------------------------------------
// XA ADPCM predictor history
// Holds the two most recent decoded samples of every channel.
// ----------------------------------------------------------------------------
module xad_history
    import xad_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEFAULT,
    parameter int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] slot,
    input  hist_wr_t         wr,
    output hist_pair_t       rd
);

    sample_t newest_reg [NUM_CHANNELS];
    sample_t older_reg  [NUM_CHANNELS];

    assign rd.newest = newest_reg[slot];
    assign rd.older  = older_reg[slot];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                newest_reg[i] <= '0;
                older_reg[i]  <= '0;
            end
        end
        else if (wr.en)
        begin
            older_reg[slot]  <= newest_reg[slot];
            newest_reg[slot] <= wr.data;
        end
    end

endmodule

/* rtl/core/xad_predictor.sv */
// ----------------------------------------------------------------------------
// XA ADPCM predictor
// Scales one code by the unit range, adds the filtered history and saturates.
// ----------------------------------------------------------------------------
module xad_predictor
    import xad_pkg::*;
(
    input  logic [CODE_W-1:0]   code,
    input  logic [HEADER_W-1:0] header,
    input  hist_pair_t          hist,
    output sample_t             pcm
);

    logic [3:0]         range_val;
    logic [1:0]         filt;
    logic [3:0]         shift;
    logic signed [16:0] code_ext;
    logic signed [16:0] scaled;
    coef_t              ka;
    coef_t              kb;
    logic signed [25:0] ka_ext;
    logic signed [25:0] kb_ext;
    logic signed [25:0] newest_ext;
    logic signed [25:0] older_ext;
    logic signed [25:0] prod_a;
    logic signed [25:0] prod_b;
    logic signed [26:0] pred;
    logic signed [26:0] pred_adj;
    logic signed [18:0] quot;
    logic signed [19:0] acc;

    assign range_val = header[3:0];
    assign filt      = header[5:4];
    assign shift     = (range_val > MAX_RANGE) ? 4'd0 : (MAX_RANGE - range_val);

    assign code_ext = {{13{code[3]}}, code};
    assign scaled   = code_ext <<< shift;

    assign ka = coef_a(filt);
    assign kb = coef_b(filt);

    assign ka_ext     = {{16{ka[COEF_W-1]}}, ka};
    assign kb_ext     = {{16{kb[COEF_W-1]}}, kb};
    assign newest_ext = {{10{hist.newest[SAMPLE_W-1]}}, hist.newest};
    assign older_ext  = {{10{hist.older[SAMPLE_W-1]}}, hist.older};

    assign prod_a = ka_ext * newest_ext;
    assign prod_b = kb_ext * older_ext;
    assign pred   = {prod_a[25], prod_a} + {prod_b[25], prod_b};

    // Division by 256 rounds toward zero, so negative sums are biased first.
    assign pred_adj = pred[26] ? (pred + 27'sd255) : pred;
    assign quot     = pred_adj[26:8];
    assign acc      = {{3{scaled[16]}}, scaled} + {quot[18], quot};

    always_comb
    begin
        if (acc > 20'sd32767)
        begin
            pcm = 16'sh7fff;
        end
        else if (acc < -20'sd32768)
        begin
            pcm = 16'sh8000;
        end
        else
        begin
            pcm = acc[15:0];
        end
    end

endmodule

/* rtl/core/xa_adpcm_sample_decoder.sv */
// ----------------------------------------------------------------------------
// XA ADPCM sample decoder
// Turns one 4-bit ADPCM code per request into one saturated 16-bit sample.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while the output is not held
// by back-pressure; with a request waiting in the input register and the
// result register stalled, it stalls its input. Each accepted request passes
// through the input register and then the result register, and the single
// decode stage between them writes its per-channel history at the same edge
// as the result register, so a following request on the same channel sees
// the new history in the very next cycle.
module xa_adpcm_sample_decoder
    import xad_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // sample_code[3:0], header_byte[11:4], zero pad
    input  logic [0:0]  s_axis_tuser,   // channel[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // pcm_sample[15:0]
    output logic [0:0]  m_axis_tuser    // sample_channel[0]
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic                in_valid_reg;
    logic                in_valid_next;
    logic [CODE_W-1:0]   code_reg;
    logic [HEADER_W-1:0] header_reg;
    logic                chan_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    sample_t             pcm_reg;
    logic                out_chan_reg;

    logic                advance;
    logic                take;
    logic [IDX_W-1:0]    slot;
    hist_pair_t          hist;
    hist_wr_t            hist_wr;
    sample_t             pcm;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (int'(chan_reg) >= NUM_CHANNELS)
        begin
            slot = IDX_W'(NUM_CHANNELS - 1);
        end
        else
        begin
            slot = IDX_W'(chan_reg);
        end
    end

    assign hist_wr.en   = advance;
    assign hist_wr.data = pcm;

    xad_history #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .IDX_W        (IDX_W)
    ) u_history (
        .clk   (clk),
        .rst_n (rst_n),
        .slot  (slot),
        .wr    (hist_wr),
        .rd    (hist)
    );

    xad_predictor u_predictor (
        .code   (code_reg),
        .header (header_reg),
        .hist   (hist),
        .pcm    (pcm)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            code_reg   <= s_axis_tdata[3:0];
            header_reg <= s_axis_tdata[11:4];
            chan_reg   <= s_axis_tuser[0];
        end
        if (advance)
        begin
            pcm_reg      <= pcm;
            out_chan_reg <= chan_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = pcm_reg;
    assign m_axis_tuser  = out_chan_reg;

endmodule

/* verif/xa_adpcm_sample_decoder_tb.sv */
// ----------------------------------------------------------------------------
// XA ADPCM sample decoder testbench
// Drives nibble requests with their unit header and channel, predicts every
// decoded sample from per-channel history kept in the bench, and compares
// each result in order, under random input gaps and output back-pressure.
// ----------------------------------------------------------------------------
module xa_adpcm_sample_decoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import xad_pkg::*;

    localparam int NUM_CHAN       = 2;
    localparam int ITEM_COUNT     = 1600;
    localparam int UNIT_SAMPLES   = 28;
    localparam int DRAIN_CYCLES   = 16;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int SAT_HIGH       = 32767;
    localparam int SAT_LOW        = -32768;
    localparam int PRED_DIVISOR   = 256;
    localparam int SHIFT_BASE     = 12;

    typedef enum logic [1:0] {
        FILTER_0,
        FILTER_1,
        FILTER_2,
        FILTER_3
    } xa_filter_e;

    typedef struct {
        sample_t pcm;
        logic    chan;
    } pcm_result_t;

    typedef struct {
        logic [3:0] code;
        logic [7:0] hdr;
        logic       chan;
        bit         known;
        int         known_pcm;
    } nibble_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;     // sample_code[3:0], header_byte[11:4], zero pad
    logic [0:0]  s_axis_tuser = '0;     // channel[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // pcm_sample[15:0]
    logic [0:0]  m_axis_tuser;          // sample_channel[0]

    pcm_result_t pcm_queue[$];
    int          hist_newest [NUM_CHAN];
    int          hist_older [NUM_CHAN];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          sent_count = 0;
    int          rx_hold = 0;
    bit          steady = 1'b0;

    nibble_row_t nibble_rows [18] = '{
        '{4'h7, 8'h00, 1'b0, 1'b1, 28672},
        '{4'h7, 8'h10, 1'b0, 1'b1, 32767},
        '{4'h8, 8'h00, 1'b1, 1'b1, -32768},
        '{4'h8, 8'h10, 1'b1, 1'b1, -32768},
        '{4'h7, 8'h0D, 1'b0, 1'b1, 7},
        '{4'hF, 8'h0F, 1'b0, 1'b1, -1},
        '{4'h0, 8'h1C, 1'b0, 1'b1, 0},
        '{4'h0, 8'h2C, 1'b0, 1'b0, 0},
        '{4'h0, 8'h20, 1'b1, 1'b0, 0},
        '{4'h3, 8'h35, 1'b1, 1'b0, 0},
        '{4'h5, 8'hC4, 1'b0, 1'b1, 1280},
        '{4'h9, 8'hF3, 1'b0, 1'b0, 0},
        '{4'h4, 8'h6A, 1'b0, 1'b0, 0},
        '{4'hA, 8'hFF, 1'b1, 1'b0, 0},
        '{4'h7, 8'h20, 1'b0, 1'b0, 0},
        '{4'h7, 8'h20, 1'b0, 1'b0, 0},
        '{4'h7, 8'h30, 1'b1, 1'b0, 0},
        '{4'h8, 8'h30, 1'b1, 1'b0, 0}
    };

    xa_adpcm_sample_decoder #(
        .NUM_CHANNELS (NUM_CHAN)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 65)
            return 0;
        else if (roll < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic sample_t decode_nibble(input logic [3:0] code, input logic [7:0] hdr,
                                              input logic chan);
        int         slot;
        int         shamt;
        int         nib;
        int         k1;
        int         k2;
        int         acc;
        xa_filter_e filt;
        slot  = (chan >= NUM_CHAN) ? NUM_CHAN - 1 : int'(chan);
        shamt = (hdr[3:0] > SHIFT_BASE) ? 0 : SHIFT_BASE - int'(hdr[3:0]);
        nib   = $signed(code);
        filt  = xa_filter_e'(hdr[5:4]);
        case (filt)
            FILTER_1:
            begin
                k1 = 240;
                k2 = 0;
            end
            FILTER_2:
            begin
                k1 = 460;
                k2 = -208;
            end
            FILTER_3:
            begin
                k1 = 392;
                k2 = -220;
            end
            default:
            begin
                k1 = 0;
                k2 = 0;
            end
        endcase
        acc = nib * (1 << shamt)
            + (k1 * hist_newest[slot] + k2 * hist_older[slot]) / PRED_DIVISOR;
        if (acc > SAT_HIGH)
            acc = SAT_HIGH;
        else if (acc < SAT_LOW)
            acc = SAT_LOW;
        hist_older[slot]  = hist_newest[slot];
        hist_newest[slot] = acc;
        return sample_t'(acc);
    endfunction

    task automatic send_nibble(input logic [3:0] code, input logic [7:0] hdr, input logic chan,
                               input bit known, input int known_pcm);
        int          gap;
        sample_t     predicted;
        pcm_result_t entry;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, hdr, code};
        s_axis_tuser  <= chan;
        do @(posedge clk); while (!s_axis_tready);
        predicted  = decode_nibble(code, hdr, chan);
        entry.pcm  = known ? sample_t'(known_pcm) : predicted;
        entry.chan = chan;
        pcm_queue.push_back(entry);
        sent_count++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pcm_queue.size() != 0);
    endtask

    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            rx_hold = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        pcm_result_t wanted;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pcm_queue.size() == 0)
            begin
                $error("pcm_sample: no result expected, actual %0d", $signed(m_axis_tdata));
                mismatch_count++;
            end
            else
            begin
                wanted = pcm_queue.pop_front();
                if (m_axis_tdata !== wanted.pcm)
                begin
                    $error("pcm_sample: expected %0d, actual %0d",
                           wanted.pcm, $signed(m_axis_tdata));
                    mismatch_count++;
                end
                if (m_axis_tuser[0] !== wanted.chan)
                begin
                    $error("sample_channel: expected %0d, actual %0d",
                           wanted.chan, m_axis_tuser[0]);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int         roll;
        int         mono_chan;
        bit         stereo;
        logic [7:0] hdr;
        logic [3:0] range;
        xa_filter_e filt;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            hist_newest[c] = 0;
            hist_older[c]  = 0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (nibble_rows[i])
            send_nibble(nibble_rows[i].code, nibble_rows[i].hdr, nibble_rows[i].chan,
                        nibble_rows[i].known, nibble_rows[i].known_pcm);
        drain_results();

        while (sent_count < ITEM_COUNT)
        begin
            steady = ($urandom_range(0, 7) == 0);
            roll   = $urandom_range(0, 99);
            if (roll < 80)
            begin
                if ($urandom_range(0, 99) < 85)
                    range = 4'($urandom_range(0, 12));
                else
                    range = 4'($urandom_range(13, 15));
                filt      = xa_filter_e'($urandom_range(0, 3));
                hdr       = {2'($urandom), filt, range};
                stereo    = 1'($urandom);
                mono_chan = $urandom_range(0, 1);
                for (int i = 0; i < UNIT_SAMPLES; i++)
                    send_nibble(4'($urandom), hdr, stereo ? i[0] : 1'(mono_chan), 1'b0, 0);
            end
            else if (roll < 96)
            begin
                repeat (8)
                    send_nibble(4'($urandom), 8'($urandom), 1'($urandom), 1'b0, 0);
            end
            else
            begin
                drain_results();
            end
        end

        steady = 1'b0;
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pcm_queue.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
